[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/cssm_pkg.sv]
`timescale 1ns / 1ps
package cssm_pkg;

    localparam int FRAC_BITS         = 4;
    localparam int MAX_FRAME_SAMPLES = 4096;
    localparam int MAX_STEPS         = 16;

    localparam int XW   = 28;
    localparam int AW   = 29;
    localparam int BW   = 18;
    localparam int ACCW = 48;
    localparam int DENW = 18;
    localparam int QW   = 30;
    localparam int RESW = QW + 1;

    localparam logic [2:0] REG_VMIN  = 3'd0;
    localparam logic [2:0] REG_VMAX  = 3'd1;
    localparam logic [2:0] REG_PW    = 3'd2;
    localparam logic [2:0] REG_PH    = 3'd3;
    localparam logic [2:0] REG_CAP   = 3'd4;
    localparam logic [2:0] REG_STEPS = 3'd5;
    localparam logic [2:0] REG_EXT   = 3'd6;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [15:0] sat16(input logic signed [RESW-1:0] v);
        logic [15:0] r;
        if (v[RESW-1]) begin
            r = 16'd0;
        end else if (|v[RESW-2:16]) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[sv/cssm_mac.sv]
`timescale 1ns / 1ps
module cssm_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_clr,
    input  logic signed [cssm_pkg::AW-1:0]     i_a,
    input  logic signed [cssm_pkg::BW-1:0]     i_b,
    output logic signed [cssm_pkg::ACCW-1:0]   o_acc
);

    logic signed [cssm_pkg::AW+cssm_pkg::BW-1:0] r_prod;
    logic                                        r_pv;
    logic                                        r_pclr;
    logic signed [cssm_pkg::ACCW-1:0]            r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pclr <= i_clr;
        r_prod <= i_a * i_b;
        if (r_pv) begin
            r_acc <= (r_pclr ? '0 : r_acc) + cssm_pkg::ACCW'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

[sv/cssm_div.sv]
`timescale 1ns / 1ps
module cssm_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [cssm_pkg::ACCW-1:0]   i_num,
    input  logic        [cssm_pkg::DENW-1:0]   i_den,
    output cssm_pkg::t_div_stat                o_stat,
    output logic signed [cssm_pkg::RESW-1:0]   o_quo
);

    logic                          r_busy;
    logic                          r_done;
    logic [4:0]                    r_cnt;
    logic                          r_neg;
    logic [cssm_pkg::ACCW-1:0]     r_rem;
    logic [cssm_pkg::ACCW-1:0]     r_dsh;
    logic [cssm_pkg::QW-1:0]       r_q;
    logic [cssm_pkg::ACCW-1:0]     w_mag;
    logic [cssm_pkg::RESW-1:0]     w_qext;

    // floor for negative numerators: magnitude -num + den - 1
    assign w_mag  = i_num[cssm_pkg::ACCW-1] ?
                    ($unsigned(~i_num) + cssm_pkg::ACCW'(i_den)) : $unsigned(i_num);
    assign w_qext = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(cssm_pkg::QW - 1);
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[cssm_pkg::ACCW-1];
            r_rem <= w_mag;
            r_dsh <= cssm_pkg::ACCW'(i_den) << (cssm_pkg::QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[cssm_pkg::QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[cssm_pkg::QW-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_neg ? -$signed(w_qext) : $signed(w_qext);

endmodule

[sv/cssm_wgt.sv]
`timescale 1ns / 1ps
module cssm_wgt (
    input  logic                             i_clk,
    input  logic        [4:0]                i_s,
    input  logic        [4:0]                i_n,
    output logic signed [cssm_pkg::BW-1:0]   o_k0,
    output logic signed [cssm_pkg::BW-1:0]   o_k1,
    output logic signed [cssm_pkg::BW-1:0]   o_k2,
    output logic signed [cssm_pkg::BW-1:0]   o_k3,
    output logic        [12:0]               o_n3
);

    logic [4:0]  r_s1;
    logic [4:0]  r_n1;
    logic [8:0]  r_s2;
    logic [8:0]  r_n2;
    logic [12:0] r_s3;
    logic [12:0] r_s2n;
    logic [12:0] r_sn2;
    logic [12:0] r_n3;
    logic signed [cssm_pkg::BW-1:0] w_s3;
    logic signed [cssm_pkg::BW-1:0] w_s2n;
    logic signed [cssm_pkg::BW-1:0] w_sn2;
    logic signed [cssm_pkg::BW-1:0] w_n3;
    logic signed [cssm_pkg::BW-1:0] r_k0;
    logic signed [cssm_pkg::BW-1:0] r_k1;
    logic signed [cssm_pkg::BW-1:0] r_k2;
    logic signed [cssm_pkg::BW-1:0] r_k3;
    logic        [12:0]             r_n3o;

    assign w_s3  = $signed(cssm_pkg::BW'(r_s3));
    assign w_s2n = $signed(cssm_pkg::BW'(r_s2n));
    assign w_sn2 = $signed(cssm_pkg::BW'(r_sn2));
    assign w_n3  = $signed(cssm_pkg::BW'(r_n3));

    // catmull-rom basis scaled by 2*n^3
    always_ff @(posedge i_clk) begin
        r_s1  <= i_s;
        r_n1  <= i_n;
        r_s2  <= 9'(i_s) * 9'(i_s);
        r_n2  <= 9'(i_n) * 9'(i_n);
        r_s3  <= 13'(r_s2) * 13'(r_s1);
        r_s2n <= 13'(r_s2) * 13'(r_n1);
        r_sn2 <= 13'(r_s1) * 13'(r_n2);
        r_n3  <= 13'(r_n2) * 13'(r_n1);
        r_k0  <= (w_s2n <<< 1) - w_sn2 - w_s3;
        r_k1  <= (w_n3 <<< 1) - (w_s2n <<< 2) - w_s2n + (w_s3 <<< 1) + w_s3;
        r_k2  <= w_sn2 + (w_s2n <<< 2) - (w_s3 <<< 1) - w_s3;
        r_k3  <= w_s3 - w_s2n;
        r_n3o <= r_n3;
    end

    assign o_k0 = r_k0;
    assign o_k1 = r_k1;
    assign o_k2 = r_k2;
    assign o_k3 = r_k3;
    assign o_n3 = r_n3o;

endmodule

[sv/chart_sample_spline_mapper.sv]
`timescale 1ns / 1ps
// one sample per beat; ready only while idle
// base point: from the beat to ready again, with the x mac pass and division skipped for a single x slot
// (a mac pass and a division each for x and y, then plan, emit, edge, history)
// each smoothed point: basis wait, then a mac pass and a division each for x and y, then emit
// a sample emits up to 33 points, and each emit waits while the output is stalled
// synchronous active-low reset clears the sequencer, sample history and registers to defaults
`include "assert_macros.svh"
module chart_sample_spline_mapper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample_value,
    input  logic [12:0]        i_frame_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_point_x,
    output logic [15:0]        o_point_y,
    output logic               o_frame_end
);

    localparam int XW   = cssm_pkg::XW;
    localparam int AW   = cssm_pkg::AW;
    localparam int BW   = cssm_pkg::BW;
    localparam int ACCW = cssm_pkg::ACCW;
    localparam int DENW = cssm_pkg::DENW;
    localparam int RESW = cssm_pkg::RESW;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_BX_M    = 4'd1;
    localparam logic [3:0] ST_BX_D    = 4'd2;
    localparam logic [3:0] ST_BY_M    = 4'd3;
    localparam logic [3:0] ST_BY_D    = 4'd4;
    localparam logic [3:0] ST_PLAN    = 4'd5;
    localparam logic [3:0] ST_BASE    = 4'd6;
    localparam logic [3:0] ST_SEG_W   = 4'd7;
    localparam logic [3:0] ST_SEG_MX  = 4'd8;
    localparam logic [3:0] ST_SEG_DX  = 4'd9;
    localparam logic [3:0] ST_SEG_MY  = 4'd10;
    localparam logic [3:0] ST_SEG_DY  = 4'd11;
    localparam logic [3:0] ST_SEG_OUT = 4'd12;
    localparam logic [3:0] ST_EXT     = 4'd13;
    localparam logic [3:0] ST_DONE    = 4'd14;

    // configuration
    logic signed [15:0] r_vmin;
    logic signed [15:0] r_vmax;
    logic [11:0]        r_pw;
    logic [11:0]        r_ph;
    logic [12:0]        r_capcfg;
    logic [4:0]         r_stp;
    logic               r_ext;

    // sequencer and item state
    logic [3:0]  r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [11:0] r_idx, n_idx;
    logic [12:0] r_cap, n_cap;
    logic [15:0] r_c, n_c;
    logic        r_last, n_last;
    logic        r_smooth, n_smooth;
    logic        r_ext_need, n_ext_need;
    logic [XW-1:0] r_bx, n_bx;
    logic [15:0]   r_by, n_by;
    logic [XW-1:0] r_px [4];
    logic [XW-1:0] n_px [4];
    logic [15:0]   r_py [4];
    logic [15:0]   n_py [4];
    logic [4:0]    r_s, n_s;
    logic          r_seg2, n_seg2;
    logic [15:0]   r_cx, n_cx;
    logic [15:0]   r_cy, n_cy;
    logic [XW-1:0] r_rx [3];
    logic [XW-1:0] n_rx [3];
    logic [15:0]   r_ry [3];
    logic [15:0]   n_ry [3];
    logic          r_ovalid, n_ovalid;
    logic [15:0]   r_ox, n_ox;
    logic [15:0]   r_oy, n_oy;
    logic          r_ofe, n_ofe;

    // derived values
    logic [11:0]        w_w;
    logic [11:0]        w_h;
    logic [15:0]        w_w16;
    logic [15:0]        w_h16;
    logic [4:0]         w_steps;
    logic signed [16:0] w_spanraw;
    logic [15:0]        w_span;
    logic signed [16:0] w_diff;
    logic [12:0]        w_nc;
    logic               w_out_free;
    logic               w_accept;
    logic [ACCW-1:0]    w_n3x;
    logic signed [RESW-1:0] w_p1;
    logic signed [RESW-1:0] w_p2;
    logic signed [RESW-1:0] w_tx;
    logic signed [RESW-1:0] w_tx2;
    logic signed [RESW-1:0] w_h16s;
    logic signed [RESW-1:0] w_ty;

    // shared units
    logic                   mac_en;
    logic                   mac_clr;
    logic signed [AW-1:0]   mac_a;
    logic signed [BW-1:0]   mac_b;
    logic signed [ACCW-1:0] mac_acc;
    logic                   div_start;
    logic signed [ACCW-1:0] div_num;
    logic [DENW-1:0]        div_den;
    cssm_pkg::t_div_stat    div_stat;
    logic signed [RESW-1:0] div_quo;
    logic signed [BW-1:0]   k0;
    logic signed [BW-1:0]   k1;
    logic signed [BW-1:0]   k2;
    logic signed [BW-1:0]   k3;
    logic [12:0]            n3;
    logic signed [BW-1:0]   w_ksel;

    cssm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (mac_en),
        .i_clr   (mac_clr),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    cssm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    cssm_wgt u_wgt (
        .i_clk (i_clk),
        .i_s   (r_s),
        .i_n   (w_steps),
        .o_k0  (k0),
        .o_k1  (k1),
        .o_k2  (k2),
        .o_k3  (k3),
        .o_n3  (n3)
    );

    assign w_w      = (r_pw == 12'd0) ? 12'd1 : r_pw;
    assign w_h      = (r_ph == 12'd0) ? 12'd1 : r_ph;
    assign w_w16    = 16'(w_w) << cssm_pkg::FRAC_BITS;
    assign w_h16    = 16'(w_h) << cssm_pkg::FRAC_BITS;
    assign w_steps  = (r_stp == 5'd0) ? 5'd1 :
                      (r_stp > 5'(cssm_pkg::MAX_STEPS)) ? 5'(cssm_pkg::MAX_STEPS) : r_stp;
    assign w_spanraw = $signed({r_vmax[15], r_vmax}) - $signed({r_vmin[15], r_vmin});
    assign w_span    = (w_spanraw < 17'sd1) ? 16'd1 : w_spanraw[15:0];
    assign w_diff    = $signed({i_sample_value[15], i_sample_value})
                     - $signed({r_vmin[15], r_vmin});
    assign w_nc      = (i_frame_count == 13'd0) ? 13'd1 :
                       (i_frame_count > 13'(cssm_pkg::MAX_FRAME_SAMPLES)) ?
                       13'(cssm_pkg::MAX_FRAME_SAMPLES) : i_frame_count;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_n3x      = ACCW'(n3);

    // curve point clamps
    assign w_p1   = $signed(RESW'(r_px[1]));
    assign w_p2   = $signed(RESW'(r_px[2]));
    assign w_tx   = (div_quo < w_p1) ? w_p1 : div_quo;
    assign w_tx2  = (w_tx > w_p2) ? w_p2 : w_tx;
    assign w_h16s = $signed(RESW'(w_h16));
    assign w_ty   = div_quo[RESW-1] ? '0 : ((div_quo > w_h16s) ? w_h16s : div_quo);

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    w_ksel = k0;
            2'd1:    w_ksel = k1;
            2'd2:    w_ksel = k2;
            default: w_ksel = k3;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_cap      = r_cap;
        n_c        = r_c;
        n_last     = r_last;
        n_smooth   = r_smooth;
        n_ext_need = r_ext_need;
        n_bx       = r_bx;
        n_by       = r_by;
        n_px       = r_px;
        n_py       = r_py;
        n_s        = r_s;
        n_seg2     = r_seg2;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_rx       = r_rx;
        n_ry       = r_ry;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_ox       = r_ox;
        n_oy       = r_oy;
        n_ofe      = r_ofe;
        mac_en     = 1'b0;
        mac_clr    = 1'b0;
        mac_a      = '0;
        mac_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cap    = (r_capcfg > w_nc) ? r_capcfg : w_nc;
                    n_last   = (13'(r_idx) + 13'd1) >= w_nc;
                    n_smooth = (w_steps > 5'd1) && (w_nc >= 13'd3);
                    n_c      = w_diff[16] ? 16'd0 :
                               (w_diff > $signed({1'b0, w_span})) ? w_span : w_diff[15:0];
                    n_cnt    = '0;
                    n_state  = ST_BX_M;
                end
            end
            ST_BX_M: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd0) begin
                    if (r_cap <= 13'd1) begin
                        n_bx    = '0;
                        n_cnt   = '0;
                        n_state = ST_BY_M;
                    end else begin
                        mac_en  = 1'b1;
                        mac_clr = 1'b1;
                        mac_a   = $signed(AW'(r_idx));
                        mac_b   = $signed(BW'(w_w));
                    end
                end else if (r_cnt == 3'd2) begin
                    div_start = 1'b1;
                    div_num   = $signed(($unsigned(mac_acc) << (cssm_pkg::FRAC_BITS + 1))
                                + ACCW'(r_cap - 13'd1));
                    div_den   = DENW'({r_cap - 13'd1, 1'b0});
                    n_state   = ST_BX_D;
                end
            end
            ST_BX_D: begin
                if (div_stat.done) begin
                    n_bx    = div_quo[XW-1:0];
                    n_cnt   = '0;
                    n_state = ST_BY_M;
                end
            end
            ST_BY_M: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd0) begin
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                    mac_a   = $signed(AW'(r_c));
                    mac_b   = $signed(BW'(w_h));
                end else if (r_cnt == 3'd2) begin
                    div_start = 1'b1;
                    div_num   = $signed(($unsigned(mac_acc) << (cssm_pkg::FRAC_BITS + 1))
                                + ACCW'(w_span));
                    div_den   = DENW'({w_span, 1'b0});
                    n_state   = ST_BY_D;
                end
            end
            ST_BY_D: begin
                if (div_stat.done) begin
                    n_by    = w_h16 - div_quo[15:0];
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                n_ext_need = r_last && r_ext && (r_bx < XW'(w_w16));
                n_cnt      = '0;
                if (!r_smooth || r_idx == 12'd0) begin
                    n_state = ST_BASE;
                end else if (r_idx >= 12'd2) begin
                    n_px[0] = (r_idx >= 12'd3) ? r_rx[2] : r_rx[1];
                    n_py[0] = (r_idx >= 12'd3) ? r_ry[2] : r_ry[1];
                    n_px[1] = r_rx[1];
                    n_py[1] = r_ry[1];
                    n_px[2] = r_rx[0];
                    n_py[2] = r_ry[0];
                    n_px[3] = r_bx;
                    n_py[3] = r_by;
                    n_s     = 5'd1;
                    n_seg2  = 1'b0;
                    n_state = ST_SEG_W;
                end else begin
                    n_state = ST_EXT;
                end
            end
            ST_BASE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ox     = cssm_pkg::sat16($signed(RESW'(r_bx)));
                    n_oy     = r_by;
                    n_ofe    = r_last && !r_ext_need;
                    n_state  = ST_EXT;
                end
            end
            ST_SEG_W: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_cnt   = '0;
                    n_state = ST_SEG_MX;
                end
            end
            ST_SEG_MX, ST_SEG_MY: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt <= 3'd3) begin
                    mac_en  = 1'b1;
                    mac_clr = (r_cnt == 3'd0);
                    mac_a   = (r_state == ST_SEG_MX) ? $signed(AW'(r_px[r_cnt[1:0]]))
                                                     : $signed(AW'(r_py[r_cnt[1:0]]));
                    mac_b   = w_ksel;
                end else if (r_cnt == 3'd5) begin
                    div_start = 1'b1;
                    div_num   = mac_acc + $signed(w_n3x);
                    div_den   = DENW'({n3, 1'b0});
                    n_state   = (r_state == ST_SEG_MX) ? ST_SEG_DX : ST_SEG_DY;
                end
            end
            ST_SEG_DX: begin
                if (div_stat.done) begin
                    n_cx    = cssm_pkg::sat16(w_tx2);
                    n_cnt   = '0;
                    n_state = ST_SEG_MY;
                end
            end
            ST_SEG_DY: begin
                if (div_stat.done) begin
                    n_cy    = w_ty[15:0];
                    n_state = ST_SEG_OUT;
                end
            end
            ST_SEG_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ox     = r_cx;
                    n_oy     = r_cy;
                    n_ofe    = r_seg2 && (r_s == w_steps) && !r_ext_need;
                    n_cnt    = '0;
                    if (r_s == w_steps) begin
                        if (r_last && !r_seg2) begin
                            n_px[0] = r_rx[1];
                            n_py[0] = r_ry[1];
                            n_px[1] = r_rx[0];
                            n_py[1] = r_ry[0];
                            n_px[2] = r_bx;
                            n_py[2] = r_by;
                            n_px[3] = r_bx;
                            n_py[3] = r_by;
                            n_s     = 5'd1;
                            n_seg2  = 1'b1;
                            n_state = ST_SEG_W;
                        end else begin
                            n_state = ST_EXT;
                        end
                    end else begin
                        n_s     = r_s + 5'd1;
                        n_state = ST_SEG_W;
                    end
                end
            end
            ST_EXT: begin
                if (!r_ext_need) begin
                    n_state = ST_DONE;
                end else if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ox     = w_w16;
                    n_oy     = r_by;
                    n_ofe    = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                n_rx[2] = r_rx[1];
                n_ry[2] = r_ry[1];
                n_rx[1] = r_rx[0];
                n_ry[1] = r_ry[0];
                n_rx[0] = r_bx;
                n_ry[0] = r_by;
                n_idx   = r_last ? 12'd0 : r_idx + 12'd1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_rx[0]  <= '0;
            r_rx[1]  <= '0;
            r_rx[2]  <= '0;
            r_ry[0]  <= '0;
            r_ry[1]  <= '0;
            r_ry[2]  <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            r_rx     <= n_rx;
            r_ry     <= n_ry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap      <= n_cap;
        r_c        <= n_c;
        r_last     <= n_last;
        r_smooth   <= n_smooth;
        r_ext_need <= n_ext_need;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_px       <= n_px;
        r_py       <= n_py;
        r_s        <= n_s;
        r_seg2     <= n_seg2;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_ox       <= n_ox;
        r_oy       <= n_oy;
        r_ofe      <= n_ofe;
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin   <= 16'sd0;
            r_vmax   <= 16'sd100;
            r_pw     <= 12'd400;
            r_ph     <= 12'd200;
            r_capcfg <= 13'd0;
            r_stp    <= 5'd1;
            r_ext    <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                cssm_pkg::REG_VMIN:  r_vmin   <= pwdata[15:0];
                cssm_pkg::REG_VMAX:  r_vmax   <= pwdata[15:0];
                cssm_pkg::REG_PW:    r_pw     <= pwdata[11:0];
                cssm_pkg::REG_PH:    r_ph     <= pwdata[11:0];
                cssm_pkg::REG_CAP:   r_capcfg <= pwdata[12:0];
                cssm_pkg::REG_STEPS: r_stp    <= pwdata[4:0];
                cssm_pkg::REG_EXT:   r_ext    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            cssm_pkg::REG_VMIN:  prdata = {16'd0, r_vmin};
            cssm_pkg::REG_VMAX:  prdata = {16'd0, r_vmax};
            cssm_pkg::REG_PW:    prdata = {20'd0, r_pw};
            cssm_pkg::REG_PH:    prdata = {20'd0, r_ph};
            cssm_pkg::REG_CAP:   prdata = {19'd0, r_capcfg};
            cssm_pkg::REG_STEPS: prdata = {27'd0, r_stp};
            cssm_pkg::REG_EXT:   prdata = {31'd0, r_ext};
            default:             prdata = 32'd0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_point_x   = r_ox;
    assign o_point_y   = r_oy;
    assign o_frame_end = r_ofe;

    `ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_accept, !o_in_ready)
    `ASSERT_IMPLIES(a_div_free_on_start, i_clk, i_rst_n, div_start, !div_stat.busy)
    `ASSERT_IMPLIES(a_step_in_range, i_clk, i_rst_n, r_state == ST_SEG_W, r_s != 5'd0 && r_s <= w_steps)

endmodule
